>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/sufp_pkg.sv
// ----------------------------------------------------------------------------
// sufp_pkg
// Types, constants and helpers of the sensor serial line and frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sufp_pkg;

    localparam int unsigned FRAME_CAPACITY = 320;
    localparam int unsigned FILL_W         = $clog2(FRAME_CAPACITY + 1);
    localparam int unsigned LEN_W          = 9;
    localparam int unsigned DIST_W         = 16;

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = LEN_W'(240);
    localparam logic [15:0]      DIST_MAX       = 16'hFFFF;
    localparam logic [4:0]       SUFFIX_LEN     = 5'd10;

    localparam logic [31:0] CMD_HEAD  = 32'hFDFCFBFA;
    localparam logic [31:0] CMD_TAIL  = 32'h04030201;
    localparam logic [31:0] DATA_HEAD = 32'hF4F3F2F1;
    localparam logic [31:0] DATA_TAIL = 32'hF8F7F6F5;

    localparam logic [3:0] KEY_LEN = 4'd9;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_D     = 8'h64;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_OFF       = 3'd1,
        EV_DISTANCE  = 3'd2,
        EV_BODY_BYTE = 3'd3,
        EV_CMD_END   = 3'd4,
        EV_DATA_END  = 3'd5,
        EV_ABORT     = 3'd6
    } t_event;

    // characters of "distance:"
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = 8'h64;
            4'd1:    c = 8'h69;
            4'd2:    c = 8'h73;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h63;
            4'd7:    c = 8'h65;
            4'd8:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sufp_rx_if.sv
// ----------------------------------------------------------------------------
// sufp_rx_if
// Received byte channel: valid, ready and one byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sufp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sufp_cfg_if.sv
// ----------------------------------------------------------------------------
// sufp_cfg_if
// Configuration write channel for the body length limit.
// ----------------------------------------------------------------------------
`default_nettype none

interface sufp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sufp_pkg::LEN_W-1:0]    max_body_length;

    modport source (output valid, output max_body_length, input ready);
    modport sink   (input valid, input max_body_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sufp_res_if.sv
// ----------------------------------------------------------------------------
// sufp_res_if
// Parse result channel: event code and its associated fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sufp_res_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    event_res;
    logic [sufp_pkg::DIST_W-1:0]   range_value;
    logic [sufp_pkg::LEN_W-1:0]    frame_body_length;
    logic [7:0]                    body_byte;
    logic [sufp_pkg::LEN_W-1:0]    body_index;

    modport source (output valid, output event_res, output range_value,
                    output frame_body_length, output body_byte, output body_index,
                    input ready);
    modport sink   (input valid, input event_res, input range_value,
                    input frame_body_length, input body_byte, input body_index,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/sufp_in_reg.sv
// ----------------------------------------------------------------------------
// sufp_in_reg
// Input register stage for received bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sufp_in_reg (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sufp_rx_if.sink    i_rx,
    sufp_rx_if.source  o_rx
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready   = !r_valid || o_rx.ready;
    assign o_rx.valid   = r_valid;
    assign o_rx.rx_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_valid <= 1'b1;
        end else if (o_rx.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sufp_parser.sv
// ----------------------------------------------------------------------------
// sufp_parser
// Line and frame parse step with state, length limit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sufp_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sufp_rx_if.sink    i_rx,
    sufp_cfg_if.sink   i_cfg,
    sufp_res_if.source o_res
);

    localparam int unsigned FW = sufp_pkg::FILL_W;
    localparam int unsigned LW = sufp_pkg::LEN_W;
    localparam int unsigned DW = sufp_pkg::DIST_W;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_SAW_O    = 4'd1,
        ST_SAW_OF   = 4'd2,
        ST_SAW_OFF  = 4'd3,
        ST_OFF_TERM = 4'd4,
        ST_KEY      = 4'd5,
        ST_NUM      = 4'd6,
        ST_NUM_TERM = 4'd7,
        ST_LEN_LO   = 4'd8,
        ST_LEN_HI   = 4'd9,
        ST_BODY     = 4'd10,
        ST_SUFFIX   = 4'd11
    } t_state;

    t_state           r_state,  n_state;
    logic [31:0]      r_window, n_window;
    logic [2:0]       r_wfill,  n_wfill;
    logic [7:0]       r_prev;
    logic [3:0]       r_kpos,   n_kpos;
    logic [DW-1:0]    r_acc,    n_acc;
    logic             r_digit,  n_digit;
    logic [FW-1:0]    r_ffill,  n_ffill;
    logic [LW-1:0]    r_decl,   n_decl;
    logic [LW-1:0]    r_count,  n_count;
    logic [LW-1:0]    r_max;

    logic             r_res_valid;
    sufp_pkg::t_event r_ev;
    logic [DW-1:0]    r_dist;
    logic [LW-1:0]    r_blen;
    logic [7:0]       r_bbyte;
    logic [LW-1:0]    r_bidx;

    sufp_pkg::t_event n_ev;
    logic [DW-1:0]    n_dist;
    logic [LW-1:0]    n_blen;
    logic [7:0]       n_bbyte;
    logic [LW-1:0]    n_bidx;

    logic             step;
    logic [7:0]       b;
    logic             full;
    logic             in_frame;
    logic [15:0]      len16;
    logic [16:0]      len_plus;
    logic [19:0]      acc_next;

    function automatic logic term_pair(input logic [7:0] a, input logic [7:0] c);
        return (a == sufp_pkg::CH_CR && c == sufp_pkg::CH_LF) ||
               (a == sufp_pkg::CH_LF && c == sufp_pkg::CH_CR);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !r_res_valid || o_res.ready;
    assign step        = i_rx.valid && i_rx.ready;
    assign b           = i_rx.rx_byte;

    assign o_res.valid             = r_res_valid;
    assign o_res.event_res         = r_ev;
    assign o_res.range_value       = r_dist;
    assign o_res.frame_body_length = r_blen;
    assign o_res.body_byte         = r_bbyte;
    assign o_res.body_index        = r_bidx;

    assign n_window = {r_window[23:0], b};
    assign n_wfill  = (r_wfill == 3'd4) ? r_wfill : r_wfill + 3'd1;
    assign full     = (n_wfill == 3'd4);
    assign in_frame = (r_state == ST_LEN_LO) || (r_state == ST_LEN_HI) ||
                      (r_state == ST_BODY) || (r_state == ST_SUFFIX);
    assign len16    = {b, r_decl[7:0]};
    assign len_plus = {1'b0, len16} + 17'(sufp_pkg::SUFFIX_LEN);
    assign acc_next = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) +
                      20'(b - sufp_pkg::CH_ZERO);

    always_comb begin
        n_state = r_state;
        n_kpos  = r_kpos;
        n_acc   = r_acc;
        n_digit = r_digit;
        n_ffill = r_ffill;
        n_decl  = r_decl;
        n_count = r_count;
        n_ev    = sufp_pkg::EV_NONE;
        n_dist  = '0;
        n_blen  = '0;
        n_bbyte = '0;
        n_bidx  = '0;

        if (in_frame) begin
            if (r_ffill >= FW'(sufp_pkg::FRAME_CAPACITY)) begin
                n_state = ST_IDLE;
                n_ffill = '0;
                n_decl  = '0;
                n_count = '0;
                n_kpos  = '0;
                n_acc   = '0;
                n_digit = 1'b0;
                n_ev    = sufp_pkg::EV_ABORT;
            end else begin
                n_ffill = r_ffill + FW'(1);
                unique case (r_state)
                    ST_LEN_LO: begin
                        n_decl  = LW'(b);
                        n_state = ST_LEN_HI;
                    end
                    ST_LEN_HI: begin
                        if (len16 > 16'(r_max) ||
                            len_plus > 17'(sufp_pkg::FRAME_CAPACITY)) begin
                            n_state = ST_IDLE;
                            n_ffill = '0;
                            n_decl  = '0;
                            n_count = '0;
                            n_kpos  = '0;
                            n_acc   = '0;
                            n_digit = 1'b0;
                            n_ev    = sufp_pkg::EV_ABORT;
                        end else begin
                            n_decl  = len16[LW-1:0];
                            n_count = '0;
                            n_state = (len16 == 16'd0) ? ST_SUFFIX : ST_BODY;
                        end
                    end
                    ST_BODY: begin
                        n_ev    = sufp_pkg::EV_BODY_BYTE;
                        n_blen  = r_decl;
                        n_bbyte = b;
                        n_bidx  = r_count;
                        n_count = r_count + LW'(1);
                        if (n_count >= r_decl) begin
                            n_state = ST_SUFFIX;
                        end
                    end
                    default: begin
                        if (full && (n_window == sufp_pkg::CMD_TAIL ||
                                     n_window == sufp_pkg::DATA_TAIL)) begin
                            n_ev    = (n_window == sufp_pkg::CMD_TAIL) ?
                                      sufp_pkg::EV_CMD_END : sufp_pkg::EV_DATA_END;
                            n_blen  = r_decl;
                            n_state = ST_IDLE;
                            n_ffill = '0;
                            n_decl  = '0;
                            n_count = '0;
                            n_kpos  = '0;
                            n_acc   = '0;
                            n_digit = 1'b0;
                        end
                    end
                endcase
            end
        end else if (full && (n_window == sufp_pkg::CMD_HEAD ||
                              n_window == sufp_pkg::DATA_HEAD)) begin
            n_state = ST_LEN_LO;
            n_ffill = '0;
            n_decl  = '0;
            n_count = '0;
            n_kpos  = '0;
            n_acc   = '0;
            n_digit = 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (b == sufp_pkg::CH_O) begin
                        n_state = ST_SAW_O;
                    end else if (b == sufp_pkg::CH_D) begin
                        n_state = ST_KEY;
                        n_kpos  = 4'd1;
                    end
                end
                ST_SAW_O: begin
                    n_state = (b == sufp_pkg::CH_F) ? ST_SAW_OF : ST_IDLE;
                end
                ST_SAW_OF: begin
                    n_state = (b == sufp_pkg::CH_F) ? ST_SAW_OFF : ST_IDLE;
                end
                ST_SAW_OFF: begin
                    n_state = (b == sufp_pkg::CH_CR || b == sufp_pkg::CH_LF) ?
                              ST_OFF_TERM : ST_IDLE;
                end
                ST_OFF_TERM: begin
                    if (term_pair(r_prev, b)) begin
                        n_ev = sufp_pkg::EV_OFF;
                    end
                    n_state = ST_IDLE;
                end
                ST_KEY: begin
                    if (r_kpos < sufp_pkg::KEY_LEN) begin
                        if (b == sufp_pkg::key_char(r_kpos)) begin
                            n_kpos = r_kpos + 4'd1;
                            if (n_kpos == sufp_pkg::KEY_LEN) begin
                                n_state = ST_NUM;
                                n_acc   = '0;
                                n_digit = 1'b0;
                            end
                        end else if (b == sufp_pkg::CH_D) begin
                            n_kpos = 4'd1;
                        end else if (b == sufp_pkg::CH_O) begin
                            n_state = ST_SAW_O;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_NUM: begin
                    if (b == sufp_pkg::CH_SPACE || b == sufp_pkg::CH_TAB) begin
                        n_state = ST_NUM;
                    end else if (b >= sufp_pkg::CH_ZERO && b <= sufp_pkg::CH_NINE) begin
                        n_digit = 1'b1;
                        n_acc   = acc_next[DW-1:0];
                        if (acc_next > 20'(sufp_pkg::DIST_MAX)) begin
                            n_state = ST_IDLE;
                        end
                    end else if (b == sufp_pkg::CH_CR || b == sufp_pkg::CH_LF) begin
                        n_state = ST_NUM_TERM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_NUM_TERM: begin
                    if (term_pair(r_prev, b) && r_digit) begin
                        n_ev   = sufp_pkg::EV_DISTANCE;
                        n_dist = r_acc;
                    end
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= '0;
            r_wfill     <= '0;
            r_prev      <= '0;
            r_kpos      <= '0;
            r_acc       <= '0;
            r_digit     <= 1'b0;
            r_ffill     <= '0;
            r_decl      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state  <= n_state;
                r_window <= n_window;
                r_wfill  <= n_wfill;
                r_prev   <= b;
                r_kpos   <= n_kpos;
                r_acc    <= n_acc;
                r_digit  <= n_digit;
                r_ffill  <= n_ffill;
                r_decl   <= n_decl;
                r_count  <= n_count;
            end
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= sufp_pkg::MAX_BODY_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max <= i_cfg.max_body_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ev    <= n_ev;
            r_dist  <= n_dist;
            r_blen  <= n_blen;
            r_bbyte <= n_bbyte;
            r_bidx  <= n_bidx;
        end
    end

    `ASSERT_ALWAYS(a_fill_cap, i_clk, i_rst_n, r_ffill <= FW'(sufp_pkg::FRAME_CAPACITY))
    `ASSERT_IMPLY(a_body_count, i_clk, i_rst_n, r_state == ST_BODY, r_count < r_decl)
    `ASSERT_IMPLY(a_body_idx, i_clk, i_rst_n,
                  r_res_valid && r_ev == sufp_pkg::EV_BODY_BYTE, r_bidx < r_blen)
    `ASSERT_IMPLY(a_len_limit, i_clk, i_rst_n,
                  r_state == ST_BODY || r_state == ST_SUFFIX,
                  {1'b0, r_decl} + (LW + 1)'(sufp_pkg::SUFFIX_LEN) <=
                  (LW + 1)'(sufp_pkg::FRAME_CAPACITY))

endmodule

`default_nettype wire

>>> rtl/core/sensor_uart_frame_line_parser.sv
// ----------------------------------------------------------------------------
// sensor_uart_frame_line_parser
// Serial byte parser for sensor text lines and binary frames.
// ----------------------------------------------------------------------------
// Channels: i_rx carries one received byte per transfer, o_res one result per
// input byte (event code, distance, body length, body byte and index), and
// i_cfg writes the largest accepted body length (always ready).
// Path: a byte taken on i_rx is held in the input register, then passes the
// parse step into the result register, from which it transfers on o_res.
// Throughput: one byte per cycle while o_res is taken, set by the parse step
// that updates the window, length and line state and loads the result register.
// Reset: all parse state clears, the window empties, the length limit
// returns to 240 and both stages drop their valid bits. No clearing pass.
// Stall: if o_res is not taken, the result register holds; the input register
// takes one more byte if empty, then i_rx.ready is low until o_res drains. The
// user makes configuration writes only while no byte is in flight; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_uart_frame_line_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sufp_rx_if.sink    i_rx,
    sufp_cfg_if.sink   i_cfg,
    sufp_res_if.source o_res
);

    sufp_rx_if rx_q ();

    sufp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_rx    (rx_q)
    );

    sufp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_q),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

>>> bench/sensor_uart_frame_line_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_uart_frame_line_parser_tb
// Self-checking bench for the sensor serial line and frame parser. Bytes go
// in through the rx channel, and a behavioral parser in the bench predicts
// the result of every transfer. A checker compares each result field by
// field, in order. Directed tests cover the text lines and the binary frames
// with their edge cases. Random phases follow, mostly well-formed lines and
// frames, under several length limits and with random stalls on both sides.
// ----------------------------------------------------------------------------
module sensor_uart_frame_line_parser_tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 40;
    localparam int PHASE_BYTES  = 15;
    localparam int NUM_PHASES   = 4;

    localparam logic [0:8][7:0] KEYWORD = "distance:";

    typedef enum logic [3:0] {
        PS_IDLE, PS_SAW_O, PS_SAW_OF, PS_SAW_OFF, PS_OFF_TERM, PS_KEY,
        PS_NUM, PS_NUM_TERM, PS_LEN_LO, PS_LEN_HI, PS_BODY, PS_SUFFIX
    } t_parse_state;

    typedef struct packed {
        sufp_pkg::t_event                ev;
        logic [sufp_pkg::DIST_W-1:0]     rng;
        logic [sufp_pkg::LEN_W-1:0]      blen;
        logic [7:0]                      bbyte;
        logic [sufp_pkg::LEN_W-1:0]      bidx;
    } t_parse_result;

    logic clk = 1'b0;
    logic rst_n;

    sufp_rx_if  rx_ch ();
    sufp_cfg_if cfg_ch ();
    sufp_res_if res_ch ();

    sensor_uart_frame_line_parser uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // predicted parser state
    logic [31:0]                win;
    int unsigned                win_fill;
    logic [7:0]                 prev_byte;
    t_parse_state               pstate;
    int unsigned                key_pos;
    int unsigned                dec_acc;
    bit                         digit_seen;
    int unsigned                frame_fill;
    int unsigned                decl_len;
    int unsigned                body_cnt;
    logic [sufp_pkg::LEN_W-1:0] body_limit;

    t_parse_result pending_results[$];

    bit rx_idle_on;
    bit res_idle_on;
    int err_count;
    int bytes_sent;
    int cfg_writes;
    int cycle_count;
    int ev_seen[8];

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic void clear_frame();
        pstate     = PS_IDLE;
        frame_fill = 0;
        decl_len   = 0;
        body_cnt   = 0;
        key_pos    = 0;
        dec_acc    = 0;
        digit_seen = 1'b0;
    endfunction

    function automatic bit line_end_pair(input logic [7:0] a, input logic [7:0] b);
        return (a == sufp_pkg::CH_CR && b == sufp_pkg::CH_LF) ||
               (a == sufp_pkg::CH_LF && b == sufp_pkg::CH_CR);
    endfunction

    function automatic t_parse_result parse_step(input logic [7:0] b);
        t_parse_result r;
        bit            in_frame;
        r        = '0;
        win      = {win[23:0], b};
        if (win_fill < 4) win_fill++;
        in_frame = (pstate == PS_LEN_LO) || (pstate == PS_LEN_HI) ||
                   (pstate == PS_BODY) || (pstate == PS_SUFFIX);
        if (in_frame) begin
            if (frame_fill >= sufp_pkg::FRAME_CAPACITY) begin
                clear_frame();
                r.ev = sufp_pkg::EV_ABORT;
            end else begin
                frame_fill++;
                case (pstate)
                    PS_LEN_LO: begin
                        decl_len = b;
                        pstate   = PS_LEN_HI;
                    end
                    PS_LEN_HI: begin
                        decl_len = decl_len | (int'(b) << 8);
                        if (decl_len > body_limit ||
                            decl_len + sufp_pkg::SUFFIX_LEN > sufp_pkg::FRAME_CAPACITY) begin
                            clear_frame();
                            r.ev = sufp_pkg::EV_ABORT;
                        end else begin
                            body_cnt = 0;
                            pstate   = (decl_len == 0) ? PS_SUFFIX : PS_BODY;
                        end
                    end
                    PS_BODY: begin
                        r.ev     = sufp_pkg::EV_BODY_BYTE;
                        r.blen   = sufp_pkg::LEN_W'(decl_len);
                        r.bbyte  = b;
                        r.bidx   = sufp_pkg::LEN_W'(body_cnt);
                        body_cnt = (body_cnt + 1) & 16'hFFFF;
                        if (body_cnt >= decl_len) pstate = PS_SUFFIX;
                    end
                    default: begin
                        if (win_fill >= 4 &&
                            (win == sufp_pkg::CMD_TAIL || win == sufp_pkg::DATA_TAIL)) begin
                            r.ev   = (win == sufp_pkg::CMD_TAIL) ?
                                     sufp_pkg::EV_CMD_END : sufp_pkg::EV_DATA_END;
                            r.blen = sufp_pkg::LEN_W'(decl_len);
                            clear_frame();
                        end
                    end
                endcase
            end
        end else if (win_fill >= 4 &&
                     (win == sufp_pkg::CMD_HEAD || win == sufp_pkg::DATA_HEAD)) begin
            clear_frame();
            pstate = PS_LEN_LO;
        end else begin
            case (pstate)
                PS_IDLE: begin
                    if (b == sufp_pkg::CH_O) begin
                        pstate = PS_SAW_O;
                    end else if (b == sufp_pkg::CH_D) begin
                        pstate  = PS_KEY;
                        key_pos = 1;
                    end
                end
                PS_SAW_O:   pstate = (b == sufp_pkg::CH_F) ? PS_SAW_OF : PS_IDLE;
                PS_SAW_OF:  pstate = (b == sufp_pkg::CH_F) ? PS_SAW_OFF : PS_IDLE;
                PS_SAW_OFF: pstate = (b == sufp_pkg::CH_CR || b == sufp_pkg::CH_LF) ?
                                     PS_OFF_TERM : PS_IDLE;
                PS_OFF_TERM: begin
                    if (line_end_pair(prev_byte, b)) r.ev = sufp_pkg::EV_OFF;
                    pstate = PS_IDLE;
                end
                PS_KEY: begin
                    if (key_pos < sufp_pkg::KEY_LEN && b == KEYWORD[key_pos]) begin
                        key_pos++;
                        if (key_pos == sufp_pkg::KEY_LEN) begin
                            pstate     = PS_NUM;
                            dec_acc    = 0;
                            digit_seen = 1'b0;
                        end
                    end else if (key_pos < sufp_pkg::KEY_LEN && b == sufp_pkg::CH_D) begin
                        key_pos = 1;
                    end else if (key_pos < sufp_pkg::KEY_LEN && b == sufp_pkg::CH_O) begin
                        pstate = PS_SAW_O;
                    end else begin
                        pstate = PS_IDLE;
                    end
                end
                PS_NUM: begin
                    if (b == sufp_pkg::CH_SPACE || b == sufp_pkg::CH_TAB) begin
                        // skipped
                    end else if (b >= sufp_pkg::CH_ZERO && b <= sufp_pkg::CH_NINE) begin
                        digit_seen = 1'b1;
                        dec_acc    = (dec_acc * 10 + (b - sufp_pkg::CH_ZERO)) & 20'hFFFFF;
                        if (dec_acc > sufp_pkg::DIST_MAX) pstate = PS_IDLE;
                    end else if (b == sufp_pkg::CH_CR || b == sufp_pkg::CH_LF) begin
                        pstate = PS_NUM_TERM;
                    end else begin
                        pstate = PS_IDLE;
                    end
                end
                PS_NUM_TERM: begin
                    if (line_end_pair(prev_byte, b) && digit_seen) begin
                        r.ev  = sufp_pkg::EV_DISTANCE;
                        r.rng = dec_acc[15:0];
                    end
                    pstate = PS_IDLE;
                end
                default: pstate = PS_IDLE;
            endcase
        end
        prev_byte = b;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch @%0d: %s got %0d expected %0d", cycle_count, what, got_v, exp_v);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int            gap;
        t_parse_result exp_r;
        gap = rx_idle_on ? $urandom_range(14, 0) : 0;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        exp_r = parse_step(b);
        pending_results.push_back(exp_r);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line(input string s, input bit lf_first);
        send_text(s);
        send_byte(lf_first ? sufp_pkg::CH_LF : sufp_pkg::CH_CR);
        send_byte(lf_first ? sufp_pkg::CH_CR : sufp_pkg::CH_LF);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
    endtask

    task automatic send_length(input logic [15:0] len);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic wait_all_results();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic set_body_limit(input logic [sufp_pkg::LEN_W-1:0] v);
        wait_all_results();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.max_body_length <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        body_limit = v;
        cfg_writes++;
    endtask

    // result side: random stall per transfer, then check against the oldest prediction
    initial begin
        t_parse_result exp_r;
        int            stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = res_idle_on ? $urandom_range(14, 0) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, event", res_ch.event_res, 0);
            end else begin
                exp_r = pending_results.pop_front();
                ev_seen[exp_r.ev]++;
                if (res_ch.event_res !== exp_r.ev)
                    report_mismatch("event_res", res_ch.event_res, exp_r.ev);
                if (res_ch.range_value !== exp_r.rng)
                    report_mismatch("range_value", res_ch.range_value, exp_r.rng);
                if (res_ch.frame_body_length !== exp_r.blen)
                    report_mismatch("frame_body_length", res_ch.frame_body_length, exp_r.blen);
                if (res_ch.body_byte !== exp_r.bbyte)
                    report_mismatch("body_byte", res_ch.body_byte, exp_r.bbyte);
                if (res_ch.body_index !== exp_r.bidx)
                    report_mismatch("body_index", res_ch.body_index, exp_r.bidx);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results pending",
                 CYCLE_LIMIT, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_text_lines();
        send_line("OFF", 1'b0);
        send_line("OFF", 1'b1);
        send_line("distance:0", 1'b0);
        send_line("distance: 6 5\t535", 1'b1);
        send_line("distance:65536", 1'b0);
        send_line("distance:", 1'b0);
        send_text("OFF");
        send_byte(sufp_pkg::CH_CR);
        send_byte(sufp_pkg::CH_CR);
        send_text("distance:12");
        send_byte(sufp_pkg::CH_LF);
        send_byte(sufp_pkg::CH_LF);
        send_line("ddistance:7", 1'b0);
        send_line("dOFF", 1'b1);
    endtask

    task automatic test_binary_frames();
        send_word(sufp_pkg::CMD_HEAD);
        send_length(16'd3);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'hFF);
        send_word(sufp_pkg::CMD_TAIL);
        // empty body
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'd0);
        send_word(sufp_pkg::DATA_TAIL);
        // suffix formed partly by the body tail
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'd3);
        send_byte(8'hF8);
        send_byte(8'hF7);
        send_byte(8'hF6);
        send_byte(8'hF5);
        // lengths above the reset limit
        send_word(sufp_pkg::CMD_HEAD);
        send_length(16'd241);
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'hFF00);
        // prefix cuts into a text line
        send_text("dista");
        send_word(sufp_pkg::CMD_HEAD);
        send_length(16'd1);
        send_byte(8'h00);
        send_word(sufp_pkg::DATA_TAIL);
    endtask

    task automatic test_body_limit_extremes();
        set_body_limit('0);
        send_word(sufp_pkg::CMD_HEAD);
        send_length(16'd0);
        send_word(sufp_pkg::CMD_TAIL);
        send_word(sufp_pkg::CMD_HEAD);
        send_length(16'd1);
        set_body_limit(sufp_pkg::LEN_W'(310));
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'd311);
        // body length exactly at the limit
        set_body_limit(sufp_pkg::LEN_W'(20));
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'd20);
        for (int i = 0; i < 20; i++) send_byte(8'(i));
        send_word(sufp_pkg::DATA_TAIL);
    endtask

    task automatic test_capacity_overrun();
        set_body_limit(sufp_pkg::LEN_W'(310));
        send_word(sufp_pkg::DATA_HEAD);
        send_length(16'd310);
        for (int i = 0; i < 310; i++) send_byte(8'($urandom_range(255, 0)));
        // fill the rest of the capacity without a suffix, then one byte more
        repeat (sufp_pkg::FRAME_CAPACITY - 312) send_byte(8'h00);
        send_byte(8'h01);
        send_line("OFF", 1'b0);
    endtask

    task automatic random_line_end();
        int k;
        k = $urandom_range(9, 0);
        if (k < 8) begin
            send_byte(k[0] ? sufp_pkg::CH_LF : sufp_pkg::CH_CR);
            send_byte(k[0] ? sufp_pkg::CH_CR : sufp_pkg::CH_LF);
        end else begin
            send_byte(k[0] ? sufp_pkg::CH_LF : sufp_pkg::CH_CR);
            send_byte(8'($urandom_range(255, 0)));
        end
    endtask

    task automatic random_segment();
        int    kind;
        int    v;
        int    len;
        string digits;
        kind = $urandom_range(9, 0);
        case (kind)
            0, 1: begin
                send_text("OFF");
                random_line_end();
            end
            2, 3, 4: begin
                case ($urandom_range(3, 0))
                    0: v = $urandom_range(999, 0);
                    1: v = $urandom_range(65535, 0);
                    2: v = $urandom_range(65540, 65530);
                    default: v = $urandom_range(99999, 0);
                endcase
                digits = $sformatf("%0d", v);
                if ($urandom_range(9, 0) == 0) send_text("distXnce:");
                else send_text("distance:");
                if ($urandom_range(9, 0) != 0) begin
                    for (int i = 0; i < digits.len(); i++) begin
                        if ($urandom_range(5, 0) == 0)
                            send_byte($urandom_range(1, 0) ? sufp_pkg::CH_SPACE :
                                                             sufp_pkg::CH_TAB);
                        send_byte(digits[i]);
                    end
                end
                random_line_end();
            end
            5, 6, 7: begin
                send_word($urandom_range(1, 0) ? sufp_pkg::CMD_HEAD : sufp_pkg::DATA_HEAD);
                case ($urandom_range(9, 0))
                    0: len = $urandom_range(body_limit, 0);
                    1: len = $urandom_range(65535, body_limit + 1);
                    default: len = $urandom_range(12, 0);
                endcase
                send_length(16'(len));
                if (len <= body_limit)
                    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255, 0)));
                case ($urandom_range(9, 0))
                    0: ;
                    1, 2: begin
                        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
                        send_word($urandom_range(1, 0) ? sufp_pkg::CMD_TAIL :
                                                         sufp_pkg::DATA_TAIL);
                    end
                    default: send_word($urandom_range(1, 0) ? sufp_pkg::CMD_TAIL :
                                                              sufp_pkg::DATA_TAIL);
                endcase
            end
            8: begin
                repeat ($urandom_range(6, 1)) begin
                    case ($urandom_range(5, 0))
                        0: send_byte(sufp_pkg::CH_CR);
                        1: send_byte(sufp_pkg::CH_LF);
                        2: send_byte(sufp_pkg::CH_D);
                        3: send_byte(sufp_pkg::CH_O);
                        default: send_byte(8'($urandom_range(255, 0)));
                    endcase
                end
            end
            default: begin
                v = $urandom_range(1, 0) ? sufp_pkg::CMD_HEAD : sufp_pkg::DATA_HEAD;
                send_byte(v[31:24]);
                send_byte(v[23:16]);
                send_byte(v[15:8]);
                send_byte(8'($urandom_range(255, 0)));
            end
        endcase
    endtask

    task automatic test_random_traffic();
        int phase_start;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_body_limit(sufp_pkg::MAX_BODY_RESET);
                1: set_body_limit(sufp_pkg::LEN_W'(310));
                2: set_body_limit('0);
                default: set_body_limit(sufp_pkg::LEN_W'($urandom_range(310, 0)));
            endcase
            rx_idle_on  = (phase % 4) < 2;
            res_idle_on = (phase % 2) == 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(15, 0) == 0) begin
                    rx_idle_on  = $urandom_range(1, 0);
                    res_idle_on = $urandom_range(1, 0);
                end
                random_segment();
            end
        end
    endtask

    initial begin
        rx_ch.valid            <= 1'b0;
        rx_ch.rx_byte          <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.max_body_length <= sufp_pkg::MAX_BODY_RESET;
        rst_n                  <= 1'b0;
        win         = '0;
        win_fill    = 0;
        prev_byte   = '0;
        body_limit  = sufp_pkg::MAX_BODY_RESET;
        clear_frame();
        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
        err_count   = 0;
        bytes_sent  = 0;
        cfg_writes  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_text_lines();
        test_binary_frames();
        test_body_limit_extremes();
        test_capacity_overrun();
        test_random_traffic();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d bytes across %0d length limit writes, %0d mismatches",
                 bytes_sent, cfg_writes, err_count);
        $display("events: off %0d, distance %0d, body %0d, cmd end %0d, data end %0d, abort %0d",
                 ev_seen[sufp_pkg::EV_OFF], ev_seen[sufp_pkg::EV_DISTANCE],
                 ev_seen[sufp_pkg::EV_BODY_BYTE], ev_seen[sufp_pkg::EV_CMD_END],
                 ev_seen[sufp_pkg::EV_DATA_END], ev_seen[sufp_pkg::EV_ABORT]);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sufp_pkg.sv
rtl/core/sufp_rx_if.sv
rtl/core/sufp_cfg_if.sv
rtl/core/sufp_res_if.sv
rtl/core/sufp_in_reg.sv
rtl/core/sufp_parser.sv
rtl/core/sensor_uart_frame_line_parser.sv
bench/sensor_uart_frame_line_parser_tb.sv
